/* rtl/bdpc_pkg.sv */
// bdpc_pkg: shared types and constants for the button debounce press classifier
// holds register indexes, reset values and the state, config and result structs
// no dependencies
package bdpc_pkg;

	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgW    = 16;
	localparam int unsigned TimeW   = 32;

	localparam logic [CfgIdxW-1:0] REG_DEBOUNCE  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_SHORT_MAX = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_LONG_MIN  = 2'd2;

	localparam logic [CfgW-1:0] DEBOUNCE_RST  = 16'd15;
	localparam logic [CfgW-1:0] SHORT_MAX_RST = 16'd1000;
	localparam logic [CfgW-1:0] LONG_MIN_RST  = 16'd3000;

	typedef struct packed {
		logic [CfgW-1:0] debounce_ms;
		logic [CfgW-1:0] short_max_ms;
		logic [CfgW-1:0] long_min_ms;
	} cfg_t;

	typedef struct packed {
		logic              raw_seen;
		logic              settling;
		logic [TimeW-1:0]  settle_start;
		logic              stable_now;
		logic              long_armed;
		logic [TimeW-1:0]  press_start;
	} state_t;

	typedef struct packed {
		logic press_event;
		logic release_event;
		logic short_press_event;
		logic long_press_event;
		logic stable_level;
	} result_t;

endpackage

/* rtl/button_debounce_press_classifier.sv */
// button_debounce_press_classifier: input register, one update step, result register
// throughput one item per cycle while out_ready does not stall the result register
// the state update sits between the input and result registers, so the next item
// sees the state left by the previous one without a stall
// arst_n clears all state: levels released, not settling, not armed, times zero,
// registers back to 15 / 1000 / 3000 ms
module button_debounce_press_classifier (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          pin_level,
	input  logic [bdpc_pkg::TimeW-1:0]    now_ms,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          press_event,
	output logic                          release_event,
	output logic                          short_press_event,
	output logic                          long_press_event,
	output logic                          stable_level,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bdpc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [bdpc_pkg::CfgW-1:0]     cfg_data
);

	bdpc_pkg::cfg_t             cfg_q;
	bdpc_pkg::state_t           state_q;
	bdpc_pkg::state_t           state_nxt;
	bdpc_pkg::result_t          res_nxt;
	bdpc_pkg::result_t          res_s2;
	logic                       valid_s1;
	logic                       pin_s1;
	logic [bdpc_pkg::TimeW-1:0] now_s1;
	logic                       adv;

	assign cfg_ready = 1'b1;
	// stage 1 moves on when the result register is free or being drained
	assign adv      = valid_s1 & (~out_valid | out_ready);
	assign in_ready = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms  <= bdpc_pkg::DEBOUNCE_RST;
			cfg_q.short_max_ms <= bdpc_pkg::SHORT_MAX_RST;
			cfg_q.long_min_ms  <= bdpc_pkg::LONG_MIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bdpc_pkg::REG_DEBOUNCE:  cfg_q.debounce_ms  <= cfg_data;
				bdpc_pkg::REG_SHORT_MAX: cfg_q.short_max_ms <= cfg_data;
				bdpc_pkg::REG_LONG_MIN:  cfg_q.long_min_ms  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pin_s1 <= pin_level;
			now_s1 <= now_ms;
		end
	end

	bdpc_step u_step (
		.pin_level (pin_s1),
		.now_ms    (now_s1),
		.cfg       (cfg_q),
		.cur       (state_q),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.raw_seen     <= 1'b1;
			state_q.settling     <= 1'b0;
			state_q.settle_start <= '0;
			state_q.stable_now   <= 1'b1;
			state_q.long_armed   <= 1'b0;
			state_q.press_start  <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	assign press_event       = res_s2.press_event;
	assign release_event     = res_s2.release_event;
	assign short_press_event = res_s2.short_press_event;
	assign long_press_event  = res_s2.long_press_event;
	assign stable_level      = res_s2.stable_level;

	// armed only while the debounced level is pressed
	a_armed_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.long_armed |-> !state_q.stable_now)
		else $error("long press armed while released");

	a_press_level: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && press_event) |-> (!stable_level && !release_event))
		else $error("press event with released level");

	a_short_release: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && short_press_event) |-> (release_event && stable_level))
		else $error("short press without release");

	a_result_level: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (stable_level == state_q.stable_now))
		else $error("result level differs from state");

	a_long_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res_nxt.long_press_event) |=> !state_q.long_armed)
		else $error("long press left armed");

endmodule

/* rtl/bdpc_step.sv */
// bdpc_step: one debounce and press classification update, purely combinational
// takes the current state, registers and one sample, gives next state and events
// depends on bdpc_pkg
module bdpc_step (
	input  logic                        pin_level,
	input  logic [bdpc_pkg::TimeW-1:0]  now_ms,
	input  bdpc_pkg::cfg_t              cfg,
	input  bdpc_pkg::state_t            cur,
	output bdpc_pkg::state_t            nxt,
	output bdpc_pkg::result_t           res
);

	logic                       raw_chg;
	logic                       settling_pre;
	logic [bdpc_pkg::TimeW-1:0] settle_start_pre;
	logic [bdpc_pkg::TimeW-1:0] settle_el;
	logic                       settle_done;
	logic                       stable_nxt;
	logic                       chg;
	logic                       press;
	logic                       release_ev;
	logic [bdpc_pkg::TimeW-1:0] hold_el;
	logic [bdpc_pkg::TimeW-1:0] long_el;
	logic                       armed_pre;
	logic                       long_hit;

	always_comb begin
		raw_chg          = pin_level != cur.raw_seen;
		settling_pre     = raw_chg | cur.settling;
		settle_start_pre = raw_chg ? now_ms : cur.settle_start;
		settle_el        = now_ms - settle_start_pre;
		settle_done      = settling_pre
			&& (settle_el >= {{(bdpc_pkg::TimeW-bdpc_pkg::CfgW){1'b0}}, cfg.debounce_ms});
		stable_nxt       = settle_done ? pin_level : cur.stable_now;

		chg        = stable_nxt != cur.stable_now;
		press      = chg & ~stable_nxt;
		release_ev = chg & stable_nxt;

		// hold time against the old start, used for the short check on release
		hold_el   = now_ms - cur.press_start;
		// a press in this step restarts the hold, so elapsed is zero
		long_el   = press ? '0 : hold_el;
		armed_pre = press | (cur.long_armed & ~release_ev);
		long_hit  = armed_pre
			&& (long_el >= {{(bdpc_pkg::TimeW-bdpc_pkg::CfgW){1'b0}}, cfg.long_min_ms});

		nxt.raw_seen     = pin_level;
		nxt.settling     = settling_pre & ~settle_done;
		nxt.settle_start = settle_start_pre;
		nxt.stable_now   = stable_nxt;
		nxt.long_armed   = armed_pre & ~long_hit;
		nxt.press_start  = press ? now_ms : cur.press_start;

		res.press_event       = press;
		res.release_event     = release_ev;
		res.short_press_event = release_ev
			&& (hold_el <= {{(bdpc_pkg::TimeW-bdpc_pkg::CfgW){1'b0}}, cfg.short_max_ms});
		res.long_press_event  = long_hit;
		res.stable_level      = stable_nxt;
	end

endmodule
